@@ rtl/core/spi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_pkg
// Shared constants and types for the segment pair intersection pipeline.
// ----------------------------------------------------------------------------
package spi_pkg;

    // Fixed width of every coordinate field on the ports
    localparam int FIELD_BITS      = 32;
    // Defaults for the top level parameters
    localparam int COORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    // Width of the crossing point adder, enough for start plus offset
    localparam int SUM_BITS        = FIELD_BITS + 3;

    // Division lanes carried through every cell
    localparam int LANES  = 4;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_T = 2;
    localparam int LANE_S = 3;

    // Advance control handed along the cell chain
    typedef struct packed {
        logic en;
        logic valid;
    } ctl_t;

endpackage

@@ rtl/core/segment_pair_intersection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_pair_intersection
// Crossing point and fractional positions of two line segments, pipelined.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  s_      | s_valid / s_ready  | a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y
//  m_      | m_valid / m_ready  | hit, cross_x/y, frac_along_a/b
//
//  One request per cycle while s_ready is high. A chain of Q division
//  cells, Q = max(COORD_BITS, FRAC_BITS) + 1, one quotient bit each, sits
//  behind six arithmetic stages.
//  Reset clears only valid flags; payload registers are not reset.
//  A stalled m_ channel fills the skid register; s_ready drops only then.
// ----------------------------------------------------------------------------
module segment_pair_intersection #(
    parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [spi_pkg::FIELD_BITS-1:0] s_a_start_x,
    input  logic [spi_pkg::FIELD_BITS-1:0] s_a_start_y,
    input  logic [spi_pkg::FIELD_BITS-1:0] s_a_end_x,
    input  logic [spi_pkg::FIELD_BITS-1:0] s_a_end_y,
    input  logic [spi_pkg::FIELD_BITS-1:0] s_b_start_x,
    input  logic [spi_pkg::FIELD_BITS-1:0] s_b_start_y,
    input  logic [spi_pkg::FIELD_BITS-1:0] s_b_end_x,
    input  logic [spi_pkg::FIELD_BITS-1:0] s_b_end_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic [spi_pkg::FIELD_BITS-1:0] m_cross_x,
    output logic [spi_pkg::FIELD_BITS-1:0] m_cross_y,
    output logic [FRAC_BITS:0]             m_frac_along_a,
    output logic [FRAC_BITS:0]             m_frac_along_b
);
    localparam int C   = COORD_BITS;
    localparam int DW  = 2 * C + 2;
    localparam int QW  = (C > FRAC_BITS) ? C + 1 : FRAC_BITS + 1;
    localparam int RW  = DW + QW;
    localparam int SBW = 2 * C + 3;

    logic en;

    logic [QW:0]                                 v_ch;
    logic [QW:0][DW-1:0]                         d_ch;
    logic [QW:0][spi_pkg::LANES-1:0][RW-1:0]     r_ch;
    logic [QW:0][spi_pkg::LANES-1:0][QW-1:0]     q_ch;
    logic [QW:0][SBW-1:0]                        sb_ch;

    assign s_ready = en;
    assign q_ch[0] = '0;

    // Arithmetic front end
    spi_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .s_valid     (s_valid),
        .s_a_start_x (s_a_start_x),
        .s_a_start_y (s_a_start_y),
        .s_a_end_x   (s_a_end_x),
        .s_a_end_y   (s_a_end_y),
        .s_b_start_x (s_b_start_x),
        .s_b_start_y (s_b_start_y),
        .s_b_end_x   (s_b_end_x),
        .s_b_end_y   (s_b_end_y),
        .valid_o     (v_ch[0]),
        .d_o         (d_ch[0]),
        .r_o         (r_ch[0]),
        .sb_o        (sb_ch[0])
    );

    // Division chain, most significant quotient bit first
    for (genvar k = 0; k < QW; k++) begin : g_cell
        spi_pkg::ctl_t ctl;
        assign ctl.en    = en;
        assign ctl.valid = v_ch[k];

        spi_cell #(
            .DW  (DW),
            .QW  (QW),
            .BIT (QW - 1 - k),
            .SBW (SBW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl_i   (ctl),
            .d_i     (d_ch[k]),
            .r_i     (r_ch[k]),
            .q_i     (q_ch[k]),
            .sb_i    (sb_ch[k]),
            .valid_o (v_ch[k+1]),
            .d_o     (d_ch[k+1]),
            .r_o     (r_ch[k+1]),
            .q_o     (q_ch[k+1]),
            .sb_o    (sb_ch[k+1])
        );
    end

    // Rounding and output buffering
    spi_out #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .valid_i        (v_ch[QW]),
        .d_i            (d_ch[QW]),
        .r_i            (r_ch[QW]),
        .q_i            (q_ch[QW]),
        .sb_i           (sb_ch[QW]),
        .pipe_ready     (en),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_cross_x      (m_cross_x),
        .m_cross_y      (m_cross_y),
        .m_frac_along_a (m_frac_along_a),
        .m_frac_along_b (m_frac_along_b)
    );

endmodule

@@ rtl/core/spi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_front
// Differences, cross products, sign normalization, hit test and the
// numerators of the four divisions, over six registered stages.
// ----------------------------------------------------------------------------
module spi_front #(
    parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   s_valid,
    input  logic [spi_pkg::FIELD_BITS-1:0]         s_a_start_x,
    input  logic [spi_pkg::FIELD_BITS-1:0]         s_a_start_y,
    input  logic [spi_pkg::FIELD_BITS-1:0]         s_a_end_x,
    input  logic [spi_pkg::FIELD_BITS-1:0]         s_a_end_y,
    input  logic [spi_pkg::FIELD_BITS-1:0]         s_b_start_x,
    input  logic [spi_pkg::FIELD_BITS-1:0]         s_b_start_y,
    input  logic [spi_pkg::FIELD_BITS-1:0]         s_b_end_x,
    input  logic [spi_pkg::FIELD_BITS-1:0]         s_b_end_y,
    output logic                                   valid_o,
    output logic [2*COORD_BITS+1:0]                d_o,
    output logic [spi_pkg::LANES-1:0][2*COORD_BITS+1+
                 ((COORD_BITS > FRAC_BITS) ? COORD_BITS+1 : FRAC_BITS+1):0] r_o,
    output logic [2*COORD_BITS+2:0]                sb_o
);
    localparam int C   = COORD_BITS;
    localparam int DFW = C + 1;
    localparam int PW  = 2 * C + 2;
    localparam int SW  = 2 * C + 3;
    localparam int DW  = 2 * C + 2;
    localparam int QW  = (C > FRAC_BITS) ? C + 1 : FRAC_BITS + 1;
    localparam int RW  = DW + QW;
    localparam int SBW = 2 * C + 3;

    // Stage 1: sign-extended differences
    logic signed [DFW-1:0] ax_c, ay_c, bx_c, by_c, px_c, py_c;
    assign ax_c = $signed({s_a_end_x[C-1], s_a_end_x[C-1:0]})
                - $signed({s_a_start_x[C-1], s_a_start_x[C-1:0]});
    assign ay_c = $signed({s_a_end_y[C-1], s_a_end_y[C-1:0]})
                - $signed({s_a_start_y[C-1], s_a_start_y[C-1:0]});
    assign bx_c = $signed({s_b_end_x[C-1], s_b_end_x[C-1:0]})
                - $signed({s_b_start_x[C-1], s_b_start_x[C-1:0]});
    assign by_c = $signed({s_b_end_y[C-1], s_b_end_y[C-1:0]})
                - $signed({s_b_start_y[C-1], s_b_start_y[C-1:0]});
    assign px_c = $signed({s_b_start_x[C-1], s_b_start_x[C-1:0]})
                - $signed({s_a_start_x[C-1], s_a_start_x[C-1:0]});
    assign py_c = $signed({s_a_start_y[C-1], s_a_start_y[C-1:0]})
                - $signed({s_b_start_y[C-1], s_b_start_y[C-1:0]});

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [DFW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, px1_reg, py1_reg;
    logic [C-1:0]          vs1_reg, ws1_reg;

    // Stage 2: products
    logic signed [PW-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DFW-1:0] bx2_reg, by2_reg;
    logic [C-1:0]          vs2_reg, ws2_reg;

    // Stage 3: denominator and numerators
    logic signed [SW-1:0]  den3_reg, sn3_reg, tn3_reg;
    logic signed [DFW-1:0] bx3_reg, by3_reg;
    logic [C-1:0]          vs3_reg, ws3_reg;

    // Stage 4: normalized magnitudes and hit flag
    logic signed [SW-1:0]  den_n, sn_n, tn_n;
    logic                  neg_den, hit_c;
    logic [DW-1:0]         d4_reg, sn4_reg, tn4_reg;
    logic [DFW-1:0]        mx4_reg, my4_reg;
    logic [SBW-1:0]        sb4_reg;

    // Stage 5: partial products of s numerator and |dB|
    logic [PW-1:0]         xlo5_reg, xhi5_reg, ylo5_reg, yhi5_reg;
    logic [DW-1:0]         d5_reg, sn5_reg, tn5_reg;
    logic [SBW-1:0]        sb5_reg;

    // Stage 6: division numerators
    logic [DW-1:0]         d6_reg;
    logic [spi_pkg::LANES-1:0][RW-1:0] r6_reg;
    logic [SBW-1:0]        sb6_reg;

    assign neg_den = den3_reg[SW-1];
    assign den_n   = neg_den ? -den3_reg : den3_reg;
    assign sn_n    = neg_den ? -sn3_reg  : sn3_reg;
    assign tn_n    = neg_den ? -tn3_reg  : tn3_reg;
    assign hit_c   = (den_n != '0) && !sn_n[SW-1] && (sn_n <= den_n)
                  && !tn_n[SW-1] && (tn_n <= den_n);

    // Advance stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg  <= ax_c;
            ay1_reg  <= ay_c;
            bx1_reg  <= bx_c;
            by1_reg  <= by_c;
            px1_reg  <= px_c;
            py1_reg  <= py_c;
            vs1_reg  <= s_b_start_x[C-1:0];
            ws1_reg  <= s_b_start_y[C-1:0];

            p0_reg   <= by1_reg * ax1_reg;
            p1_reg   <= bx1_reg * ay1_reg;
            p2_reg   <= py1_reg * ax1_reg;
            p3_reg   <= px1_reg * ay1_reg;
            p4_reg   <= px1_reg * by1_reg;
            p5_reg   <= py1_reg * bx1_reg;
            bx2_reg  <= bx1_reg;
            by2_reg  <= by1_reg;
            vs2_reg  <= vs1_reg;
            ws2_reg  <= ws1_reg;

            den3_reg <= $signed({p0_reg[PW-1], p0_reg}) - $signed({p1_reg[PW-1], p1_reg});
            sn3_reg  <= $signed({p2_reg[PW-1], p2_reg}) + $signed({p3_reg[PW-1], p3_reg});
            tn3_reg  <= $signed({p4_reg[PW-1], p4_reg}) + $signed({p5_reg[PW-1], p5_reg});
            bx3_reg  <= bx2_reg;
            by3_reg  <= by2_reg;
            vs3_reg  <= vs2_reg;
            ws3_reg  <= ws2_reg;

            d4_reg   <= den_n[DW-1:0];
            sn4_reg  <= sn_n[DW-1:0];
            tn4_reg  <= tn_n[DW-1:0];
            mx4_reg  <= bx3_reg[DFW-1] ? DFW'(-bx3_reg) : DFW'(bx3_reg);
            my4_reg  <= by3_reg[DFW-1] ? DFW'(-by3_reg) : DFW'(by3_reg);
            sb4_reg  <= {hit_c, bx3_reg[DFW-1], by3_reg[DFW-1], vs3_reg, ws3_reg};

            xlo5_reg <= sn4_reg[C:0] * mx4_reg;
            xhi5_reg <= sn4_reg[DW-1:C+1] * mx4_reg;
            ylo5_reg <= sn4_reg[C:0] * my4_reg;
            yhi5_reg <= sn4_reg[DW-1:C+1] * my4_reg;
            d5_reg   <= d4_reg;
            sn5_reg  <= sn4_reg;
            tn5_reg  <= tn4_reg;
            sb5_reg  <= sb4_reg;

            d6_reg   <= d5_reg;
            r6_reg[spi_pkg::LANE_X] <= RW'({xhi5_reg, {(C+1){1'b0}}}) + RW'(xlo5_reg);
            r6_reg[spi_pkg::LANE_Y] <= RW'({yhi5_reg, {(C+1){1'b0}}}) + RW'(ylo5_reg);
            r6_reg[spi_pkg::LANE_T] <= RW'(tn5_reg) << FRAC_BITS;
            r6_reg[spi_pkg::LANE_S] <= RW'(sn5_reg) << FRAC_BITS;
            sb6_reg  <= sb5_reg;
        end
    end

    assign valid_o = v6_reg;
    assign d_o     = d6_reg;
    assign r_o     = r6_reg;
    assign sb_o    = sb6_reg;

endmodule

@@ rtl/core/spi_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_cell
// One restoring division step for all four lanes: settles quotient bit BIT
// and hands remainders, divisor and sideband to the next cell.
// ----------------------------------------------------------------------------
module spi_cell #(
    parameter int DW  = 66,
    parameter int QW  = 33,
    parameter int BIT = 0,
    parameter int SBW = 67
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  spi_pkg::ctl_t                          ctl_i,
    input  logic [DW-1:0]                          d_i,
    input  logic [spi_pkg::LANES-1:0][DW+QW-1:0]   r_i,
    input  logic [spi_pkg::LANES-1:0][QW-1:0]      q_i,
    input  logic [SBW-1:0]                         sb_i,
    output logic                                   valid_o,
    output logic [DW-1:0]                          d_o,
    output logic [spi_pkg::LANES-1:0][DW+QW-1:0]   r_o,
    output logic [spi_pkg::LANES-1:0][QW-1:0]      q_o,
    output logic [SBW-1:0]                         sb_o
);
    localparam int RW = DW + QW;

    logic [RW-1:0]                       sh;
    logic [spi_pkg::LANES-1:0]           ge;
    logic [spi_pkg::LANES-1:0][RW-1:0]   r_next;
    logic [spi_pkg::LANES-1:0][QW-1:0]   q_next;
    logic                                valid_reg;
    logic [DW-1:0]                       d_reg;
    logic [spi_pkg::LANES-1:0][RW-1:0]   r_reg;
    logic [spi_pkg::LANES-1:0][QW-1:0]   q_reg;
    logic [SBW-1:0]                      sb_reg;

    assign sh = RW'(d_i) << BIT;

    // Trial subtract on each lane
    always_comb begin
        for (int j = 0; j < spi_pkg::LANES; j++) begin
            ge[j]          = (r_i[j] >= sh);
            r_next[j]      = ge[j] ? (r_i[j] - sh) : r_i[j];
            q_next[j]      = q_i[j];
            q_next[j][BIT] = ge[j];
        end
    end

    // Hold valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl_i.en) begin
            valid_reg <= ctl_i.valid;
        end
    end

    // Hand data to the neighbor
    always_ff @(posedge aclk) begin
        if (ctl_i.en) begin
            d_reg  <= d_i;
            r_reg  <= r_next;
            q_reg  <= q_next;
            sb_reg <= sb_i;
        end
    end

    assign valid_o = valid_reg;
    assign d_o     = d_reg;
    assign r_o     = r_reg;
    assign q_o     = q_reg;
    assign sb_o    = sb_reg;

endmodule

@@ rtl/core/spi_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_out
// Round the quotients, form the crossing point, zero a miss, and present
// the result through an output register backed by a skid register.
// ----------------------------------------------------------------------------
module spi_out #(
    parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   valid_i,
    input  logic [2*COORD_BITS+1:0]                d_i,
    input  logic [spi_pkg::LANES-1:0][2*COORD_BITS+1+
                 ((COORD_BITS > FRAC_BITS) ? COORD_BITS+1 : FRAC_BITS+1):0] r_i,
    input  logic [spi_pkg::LANES-1:0]
                 [((COORD_BITS > FRAC_BITS) ? COORD_BITS+1 : FRAC_BITS+1)-1:0] q_i,
    input  logic [2*COORD_BITS+2:0]                sb_i,
    output logic                                   pipe_ready,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_hit,
    output logic [spi_pkg::FIELD_BITS-1:0]         m_cross_x,
    output logic [spi_pkg::FIELD_BITS-1:0]         m_cross_y,
    output logic [FRAC_BITS:0]                     m_frac_along_a,
    output logic [FRAC_BITS:0]                     m_frac_along_b
);
    localparam int C   = COORD_BITS;
    localparam int DW  = 2 * C + 2;
    localparam int QW  = (C > FRAC_BITS) ? C + 1 : FRAC_BITS + 1;
    localparam int SBW = 2 * C + 3;
    localparam int OSW = spi_pkg::SUM_BITS;
    localparam int FB  = spi_pkg::FIELD_BITS;

    logic [spi_pkg::LANES-1:0][QW:0] qr;
    logic                            hit, negx, negy;
    logic [C-1:0]                    vs, ws;
    logic signed [OSW-1:0]           offx, offy, sumx, sumy;
    logic [FB-1:0]                   cx_c, cy_c;
    logic [FRAC_BITS:0]              fa_c, fb_c;

    // Round each quotient to nearest, ties to even
    always_comb begin
        logic [DW:0] two_r;
        logic [DW:0] dd;
        logic        inc;
        for (int j = 0; j < spi_pkg::LANES; j++) begin
            two_r = {r_i[j][DW-1:0], 1'b0};
            dd    = {1'b0, d_i};
            inc   = (two_r > dd) || ((two_r == dd) && q_i[j][0]);
            qr[j] = {1'b0, q_i[j]} + (QW+1)'(inc);
        end
    end

    // Form the crossing point and drop everything on a miss
    assign hit  = sb_i[SBW-1];
    assign negx = sb_i[SBW-2];
    assign negy = sb_i[SBW-3];
    assign vs   = sb_i[2*C-1:C];
    assign ws   = sb_i[C-1:0];

    assign offx = negx ? -$signed(OSW'(qr[spi_pkg::LANE_X][C:0]))
                       :  $signed(OSW'(qr[spi_pkg::LANE_X][C:0]));
    assign offy = negy ? -$signed(OSW'(qr[spi_pkg::LANE_Y][C:0]))
                       :  $signed(OSW'(qr[spi_pkg::LANE_Y][C:0]));
    assign sumx = $signed({{(OSW-C){vs[C-1]}}, vs}) + offx;
    assign sumy = $signed({{(OSW-C){ws[C-1]}}, ws}) + offy;
    assign cx_c = hit ? sumx[FB-1:0] : '0;
    assign cy_c = hit ? sumy[FB-1:0] : '0;
    assign fa_c = hit ? qr[spi_pkg::LANE_T][FRAC_BITS:0] : '0;
    assign fb_c = hit ? qr[spi_pkg::LANE_S][FRAC_BITS:0] : '0;

    // Output register with skid
    logic               m_valid_reg, m_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic               push, take, load_out, load_skid;
    logic               m_hit_reg, skid_hit_reg;
    logic [FB-1:0]      m_cx_reg, m_cy_reg, skid_cx_reg, skid_cy_reg;
    logic [FRAC_BITS:0] m_fa_reg, m_fb_reg, skid_fa_reg, skid_fb_reg;

    assign pipe_ready = !skid_valid_reg;
    assign push       = pipe_ready && valid_i;
    assign take       = m_ready || !m_valid_reg;
    assign load_out   = take && (skid_valid_reg || push);
    assign load_skid  = !take && push;

    always_comb begin
        m_valid_next    = take ? (skid_valid_reg || push) : 1'b1;
        skid_valid_next = take ? 1'b0 : (skid_valid_reg || push);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_hit_reg <= skid_valid_reg ? skid_hit_reg : hit;
            m_cx_reg  <= skid_valid_reg ? skid_cx_reg  : cx_c;
            m_cy_reg  <= skid_valid_reg ? skid_cy_reg  : cy_c;
            m_fa_reg  <= skid_valid_reg ? skid_fa_reg  : fa_c;
            m_fb_reg  <= skid_valid_reg ? skid_fb_reg  : fb_c;
        end
        if (load_skid) begin
            skid_hit_reg <= hit;
            skid_cx_reg  <= cx_c;
            skid_cy_reg  <= cy_c;
            skid_fa_reg  <= fa_c;
            skid_fb_reg  <= fb_c;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_cross_x      = m_cx_reg;
    assign m_cross_y      = m_cy_reg;
    assign m_frac_along_a = m_fa_reg;
    assign m_frac_along_b = m_fb_reg;

    // Skid holds a request only behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid full with output register empty");

    // A stalled output register must be refilled by nothing
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_cx_reg)
                                       && $stable(m_fa_reg)))
        else $error("output request changed while stalled");

    // A miss carries all-zero result fields
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_hit_reg) |-> (m_cx_reg == '0 && m_cy_reg == '0
                                         && m_fa_reg == '0 && m_fb_reg == '0))
        else $error("miss with nonzero result fields");

    // Fractions never exceed one
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_fa_reg <= ((FRAC_BITS+1)'(1) << FRAC_BITS)
                         && m_fb_reg <= ((FRAC_BITS+1)'(1) << FRAC_BITS)))
        else $error("fraction above one");

endmodule

@@ verif/segment_pair_intersection_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_pair_intersection_test
// Self-checking bench for the segment pair intersection pipeline. Directed
// geometry (extremes, parallel, degenerate, touching, rounding ties) and
// random segment pairs, with many built to cross, are streamed in bursts.
// The result side stalls on a varying pattern plus one long hold. Every
// result is checked against an exact integer prediction.
// ----------------------------------------------------------------------------
module segment_pair_intersection_test;

    localparam int FIELD_BITS = spi_pkg::FIELD_BITS;
    localparam int FB         = spi_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic [FIELD_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    typedef struct packed {
        logic                  hit;
        logic [FIELD_BITS-1:0] cx, cy;
        logic [FB:0]           fa, fb;
    } crossing_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [FIELD_BITS-1:0] s_a_start_x = '0, s_a_start_y = '0, s_a_end_x = '0, s_a_end_y = '0;
    logic [FIELD_BITS-1:0] s_b_start_x = '0, s_b_start_y = '0, s_b_end_x = '0, s_b_end_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [FIELD_BITS-1:0] m_cross_x, m_cross_y;
    logic [FB:0] m_frac_along_a, m_frac_along_b;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int   err_count = 0;
    int   requests_sent = 0;
    logic req_taken = 1'b0;
    int   gap_left = 0;
    int   burst_left = 4;
    int   hold_left = 0;
    bit   long_hold_done = 0;
    int   ready_pct = 100;
    int   stall_phase = 0;

    segment_pair_intersection dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_start_x(s_a_start_x), .s_a_start_y(s_a_start_y),
        .s_a_end_x(s_a_end_x), .s_a_end_y(s_a_end_y),
        .s_b_start_x(s_b_start_x), .s_b_start_y(s_b_start_y),
        .s_b_end_x(s_b_end_x), .s_b_end_y(s_b_end_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_cross_x(m_cross_x), .m_cross_y(m_cross_y),
        .m_frac_along_a(m_frac_along_a), .m_frac_along_b(m_frac_along_b)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Unsigned quotient, rounded to nearest with ties to even
    function automatic logic [127:0] quot_nearest(logic [127:0] n, logic [127:0] d);
        logic [127:0] q, r;
        q = n / d;
        r = n % d;
        if ((r << 1) > d || ((r << 1) == d && q[0])) q = q + 1;
        return q;
    endfunction

    // start + round(s * delta), rounding symmetric about zero
    function automatic logic [FIELD_BITS-1:0] point_on_b(logic signed [127:0] start,
            logic signed [127:0] delta, logic [127:0] s_num, logic [127:0] den);
        logic [127:0] mag, off;
        mag = delta < 0 ? -delta : delta;
        off = quot_nearest(s_num * mag, den);
        if (delta < 0) off = -off;
        return FIELD_BITS'(start + $signed(off));
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t p);
        crossing_t r;
        logic signed [127:0] x1, y1, x2, y2, v1, w1, v2, w2;
        logic signed [127:0] ax, ay, bx, by, px, py, den, sn, tn;
        x1 = $signed(p.ax0); y1 = $signed(p.ay0);
        x2 = $signed(p.ax1); y2 = $signed(p.ay1);
        v1 = $signed(p.bx0); w1 = $signed(p.by0);
        v2 = $signed(p.bx1); w2 = $signed(p.by1);
        ax = x2 - x1; ay = y2 - y1; bx = v2 - v1; by = w2 - w1;
        px = v1 - x1; py = y1 - w1;
        den = by * ax - bx * ay;
        sn = py * ax + px * ay;
        tn = px * by + py * bx;
        r = '0;
        if (den == 0) return r;
        if (den < 0) begin
            den = -den; sn = -sn; tn = -tn;
        end
        if (sn < 0 || sn > den || tn < 0 || tn > den) return r;
        r.hit = 1'b1;
        r.cx = point_on_b(v1, bx, sn, den);
        r.cy = point_on_b(w1, by, sn, den);
        r.fa = (FB + 1)'(quot_nearest(tn << FB, den));
        r.fb = (FB + 1)'(quot_nearest(sn << FB, den));
        return r;
    endfunction

    // Random coordinate of random magnitude, sign-extended from k bits
    function automatic logic [FIELD_BITS-1:0] rand_coord(int k);
        logic signed [FIELD_BITS-1:0] v;
        v = $urandom;
        return v <<< (FIELD_BITS - k) >>> (FIELD_BITS - k);
    endfunction

    function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
        seg_pair_t p;
        p.ax0 = ax0; p.ay0 = ay0; p.ax1 = ax1; p.ay1 = ay1;
        p.bx0 = bx0; p.by0 = by0; p.bx1 = bx1; p.by1 = by1;
        return p;
    endfunction

    // Queue the directed and random requests
    initial begin
        seg_pair_t p;
        int lo, hi, k;
        logic signed [FIELD_BITS-1:0] mx, my, dx, dy;
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
        // extremes: full-range diagonals crossing at the origin area, then edges, axes and points
        pending_pairs.push_back(make_pair(lo, lo, hi, hi, lo, hi, hi, lo));
        pending_pairs.push_back(make_pair(hi, hi, lo, lo, hi, lo, lo, hi));
        pending_pairs.push_back(make_pair(lo, lo, hi, lo, lo, hi, hi, hi));
        pending_pairs.push_back(make_pair(lo, 0, hi, 0, 0, lo, 0, hi));
        pending_pairs.push_back(make_pair(hi, hi, hi, hi, lo, lo, lo, lo));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        // parallel and collinear
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 1, 10, 11));
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 5, 5, 20, 20));
        // degenerate segment
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 10, 10));
        // touching at segment ends
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, -5, 10, 5));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 0, 0, 9));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 3, 0, 3, 7));
        // crossing outside one or both segments
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 11, -5, 11, 5));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 1, 5, 7));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, -3, -3, -3, -9));
        // rounding ties on the crossing point and on the fractions
        pending_pairs.push_back(make_pair(-5, 0, 5, 0, 0, -1, 1, 1));
        pending_pairs.push_back(make_pair(-5, 0, 5, 0, 1, -1, 2, 1));
        pending_pairs.push_back(make_pair(-5, 0, 5, 0, 0, -1, -1, 1));
        pending_pairs.push_back(make_pair(0, 0, 1 << 17, 0, 1, -1, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 1 << 17, 0, 3, -1, 3, 1));
        pending_pairs.push_back(make_pair(0, 0, 3, 0, 1, -1, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 7, 3, 1, 5, 6, -4));
        // random: mostly crossing pairs, rest free-form
        for (int i = 0; i < 1150; i++) begin
            k = $urandom_range(2, 32);
            p.ax0 = rand_coord(k); p.ay0 = rand_coord(k);
            p.ax1 = rand_coord(k); p.ay1 = rand_coord(k);
            if ($urandom_range(0, 9) < 6 && k <= 30) begin
                mx = ($signed(p.ax0) >>> 1) + ($signed(p.ax1) >>> 1);
                my = ($signed(p.ay0) >>> 1) + ($signed(p.ay1) >>> 1);
                dx = rand_coord(k - 1);
                dy = rand_coord(k - 1);
                p.bx0 = mx + dx; p.by0 = my + dy;
                p.bx1 = mx - dx; p.by1 = my - dy;
            end else begin
                p.bx0 = rand_coord(k); p.by0 = rand_coord(k);
                p.bx1 = rand_coord(k); p.by1 = rand_coord(k);
            end
            pending_pairs.push_back(p);
        end
    end

    // Drive requests in bursts with random gaps
    always @(negedge aclk) begin
        seg_pair_t p;
        if (aresetn && (!s_valid || req_taken)) begin
            if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_pairs.size() > 0) begin
                p = pending_pairs.pop_front();
                s_a_start_x <= p.ax0; s_a_start_y <= p.ay0;
                s_a_end_x <= p.ax1; s_a_end_y <= p.ay1;
                s_b_start_x <= p.bx0; s_b_start_y <= p.by0;
                s_b_end_x <= p.bx1; s_b_end_y <= p.by1;
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result side; hold off once for a long stretch
    always @(negedge aclk) begin
        if (!long_hold_done && requests_sent >= 300) begin
            long_hold_done <= 1;
            hold_left <= 150;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
        stall_phase <= stall_phase + 1;
        if (stall_phase % 97 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct <= 100;
                1: ready_pct <= 75;
                2: ready_pct <= 40;
                default: ready_pct <= 10;
            endcase
        end
    end

    // Predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        crossing_t e;
        seg_pair_t p;
        req_taken <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_crossings.size() == 0) begin
                $error("result with no request outstanding");
                err_count++;
            end else begin
                e = expected_crossings.pop_front();
                if (m_hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, m_hit); err_count++;
                end
                if (m_cross_x !== e.cx) begin
                    $error("cross_x: expected %0d, got %0d", $signed(e.cx), $signed(m_cross_x));
                    err_count++;
                end
                if (m_cross_y !== e.cy) begin
                    $error("cross_y: expected %0d, got %0d", $signed(e.cy), $signed(m_cross_y));
                    err_count++;
                end
                if (m_frac_along_a !== e.fa) begin
                    $error("frac_along_a: expected %0d, got %0d", e.fa, m_frac_along_a);
                    err_count++;
                end
                if (m_frac_along_b !== e.fb) begin
                    $error("frac_along_b: expected %0d, got %0d", e.fb, m_frac_along_b);
                    err_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            p = {s_a_start_x, s_a_start_y, s_a_end_x, s_a_end_y,
                 s_b_start_x, s_b_start_y, s_b_end_x, s_b_end_y};
            expected_crossings.push_back(predict_crossing(p));
            requests_sent <= requests_sent + 1;
        end
    end

    // Reset, drain, report
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_pairs.size() > 0 || s_valid || expected_crossings.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (err_count == 0 && expected_crossings.size() == 0) begin
            $display("** segment_pair_intersection: PASSED **");
        end else begin
            $display("** segment_pair_intersection: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("** segment_pair_intersection: FAILED **");
        $finish;
    end

endmodule
